// ===== rtl/esd_pkg.sv =====
package esd_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_ZERO   = 3'd2,
    PH_X      = 3'd3,
    PH_HI     = 3'd4
  } phase_t;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CTL_BEL   = 8'h07;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_HT    = 8'h09;
  localparam logic [7:0] CTL_VT    = 8'h0B;
  localparam logic [3:0] HEX_TEN   = 4'hA;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_end;
    logic       string_done;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
    phase_t     phase_next;
    logic [3:0] nib_next;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h41 + {4'h0, HEX_TEN};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h61 + {4'h0, HEX_TEN};
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CH_A:      r = CTL_BEL;
      CH_B:      r = CTL_BS;
      CH_F:      r = CTL_FF;
      CH_N:      r = CTL_LF;
      CH_R:      r = CTL_CR;
      CH_T:      r = CTL_HT;
      CH_V:      r = CTL_VT;
      CH_BSLASH: r = CH_BSLASH;
      CH_SQUOTE: r = CH_SQUOTE;
      CH_DQUOTE: r = CH_DQUOTE;
      default:   r = CH_QMARK;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/esd_decode.sv =====
module esd_decode (
  input  esd_pkg::phase_t phase,
  input  logic [3:0]      held_nibble,
  input  logic [7:0]      char_in,
  input  logic            is_final,
  output esd_pkg::dec_t   dec
);
  import esd_pkg::*;

  logic       norm_esc;
  logic [1:0] cnt;
  logic [7:0] byte0;
  logic [7:0] byte1;
  phase_t     phase_next;
  logic [3:0] nib_next;

  assign norm_esc = (char_in == CH_BSLASH) && !is_final;

  always_comb begin
    cnt        = 2'd0;
    byte0      = char_in;
    byte1      = char_in;
    phase_next = PH_NORMAL;
    nib_next   = held_nibble;
    unique case (phase)
      PH_ESC: begin
        if (char_in == CH_ZERO && !is_final) begin
          phase_next = PH_ZERO;
        end else begin
          cnt   = 2'd1;
          byte0 = (char_in == CH_ZERO) ? CH_QMARK : simple_escape(char_in);
        end
      end
      PH_ZERO: begin
        if (char_in == CH_X && !is_final) begin
          phase_next = PH_X;
        end else begin
          cnt   = 2'd1;
          byte0 = CH_QMARK;
        end
      end
      PH_X, PH_HI: begin
        if (is_hex(char_in)) begin
          cnt = 2'd1;
          if (phase == PH_HI) begin
            byte0 = {held_nibble, hex_value(char_in)};
          end else if (is_final) begin
            byte0 = CH_QMARK;
          end else begin
            cnt        = 2'd0;
            nib_next   = hex_value(char_in);
            phase_next = PH_HI;
          end
        end else begin
          byte0 = CH_QMARK;
          if (norm_esc) begin
            cnt        = 2'd1;
            phase_next = PH_ESC;
          end else begin
            cnt = 2'd2;
          end
        end
      end
      default: begin
        if (norm_esc) begin
          phase_next = PH_ESC;
        end else begin
          cnt = 2'd1;
        end
      end
    endcase
    if (phase_next != PH_HI) begin
      nib_next = 4'h0;
    end
    if (is_final) begin
      phase_next = PH_NORMAL;
      nib_next   = 4'h0;
    end
  end

  always_comb begin
    dec.cnt                  = cnt;
    dec.res0.char_out        = byte0;
    dec.res0.run_end         = (cnt == 2'd1);
    dec.res0.string_done     = (cnt == 2'd1) && is_final;
    dec.res1.char_out        = byte1;
    dec.res1.run_end         = 1'b1;
    dec.res1.string_done     = is_final;
    dec.phase_next           = phase_next;
    dec.nib_next             = nib_next;
  end

endmodule

// ===== rtl/esd_out_fifo.sv =====
module esd_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  esd_pkg::res_t push0,
  input  esd_pkg::res_t push1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_ready,
  output esd_pkg::res_t out_res
);
  import esd_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW-1:0] wr_ptr1;
  logic               pop;

  assign wr_ptr1   = wr_ptr + 1'b1;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW + 1)'(push_cnt) - (FIFO_AW + 1)'(pop);
    end
  end

endmodule

// ===== rtl/escape_sequence_decoder_unit.sv =====
// An accepted byte is registered in the input stage and decoded from there; its
// results, up to two, go into a four-entry output queue from which they are taken.
// Throughput: one input byte per cycle while the queue has room for two results;
// results leave the queue at one result per cycle while out_ready is high.
// Reset clears the escape state, the held nibble, the input stage and the queue.
module escape_sequence_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic       run_end,
  output logic       string_done
);
  import esd_pkg::*;

  logic       s_valid;
  logic [7:0] s_char;
  logic       s_final;
  phase_t     phase;
  logic [3:0] held_nibble;
  dec_t       dec;
  logic       room2;
  logic       dec_fire;
  logic [1:0] push_cnt;
  res_t       out_res;

  assign dec_fire = s_valid && room2;
  assign in_ready = !s_valid || room2;
  assign push_cnt = dec_fire ? dec.cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_char  <= char_in;
      s_final <= is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid     <= 1'b0;
      phase       <= PH_NORMAL;
      held_nibble <= 4'h0;
    end else begin
      if (in_valid && in_ready) begin
        s_valid <= 1'b1;
      end else if (dec_fire) begin
        s_valid <= 1'b0;
      end
      if (dec_fire) begin
        phase       <= dec.phase_next;
        held_nibble <= dec.nib_next;
      end
    end
  end

  esd_decode u_decode (
    .phase       (phase),
    .held_nibble (held_nibble),
    .char_in     (s_char),
    .is_final    (s_final),
    .dec         (dec)
  );

  esd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (dec.res0),
    .push1     (dec.res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign char_out    = out_res.char_out;
  assign run_end     = out_res.run_end;
  assign string_done = out_res.string_done;

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (dec_fire && s_final) |=> (phase == PH_NORMAL && held_nibble == 4'h0))
    else $error("escape state not cleared after the final byte of a string");

  a_final_yields: assert property (@(posedge clk) disable iff (rst)
    (dec_fire && s_final) |-> (dec.cnt != 2'd0))
    else $error("final byte produced no result");

  a_nibble_phase: assert property (@(posedge clk) disable iff (rst)
    (held_nibble != 4'h0) |-> (phase == PH_HI))
    else $error("held nibble set outside the second hex digit phase");

endmodule

// ===== verif/escape_decode_checker.sv =====
`timescale 1ns / 100ps

module escape_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       is_final,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] char_out,
  input  logic       run_end,
  input  logic       string_done,
  output int         mismatches,
  output int         pending
);
  import esd_pkg::*;

  phase_t     esc_phase;
  logic [3:0] nib_hold;
  res_t       decoded_q[$];
  res_t       want;
  int         errs;

  initial begin
    errs = 0;
    esc_phase = PH_NORMAL;
    nib_hold = 4'h0;
    mismatches = 0;
    pending = 0;
  end

  function automatic logic hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
      return 1'b1;
    end
    if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = b[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] outs [2];
    int         n;
    phase_t     ph;
    logic [3:0] v;
    logic       hx;
    logic       reread;
    res_t       r;
    n = 0;
    reread = 1'b0;
    ph = esc_phase;
    esc_phase = PH_NORMAL;
    hx = hex_digit(b, v);
    case (ph)
      PH_ESC: begin
        if (b == CH_ZERO && !fin) begin
          esc_phase = PH_ZERO;
        end else begin
          case (b)
            CH_A:      outs[n] = CTL_BEL;
            CH_B:      outs[n] = CTL_BS;
            CH_F:      outs[n] = CTL_FF;
            CH_N:      outs[n] = CTL_LF;
            CH_R:      outs[n] = CTL_CR;
            CH_T:      outs[n] = CTL_HT;
            CH_V:      outs[n] = CTL_VT;
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: outs[n] = b;
            default:   outs[n] = CH_QMARK;
          endcase
          n++;
        end
      end
      PH_ZERO: begin
        if (b == CH_X && !fin) begin
          esc_phase = PH_X;
        end else begin
          outs[n] = CH_QMARK;
          n++;
        end
      end
      PH_X: begin
        if (hx && !fin) begin
          nib_hold = v;
          esc_phase = PH_HI;
        end else begin
          outs[n] = CH_QMARK;
          n++;
          reread = !hx;
        end
      end
      PH_HI: begin
        if (hx) begin
          outs[n] = {nib_hold, v};
          n++;
        end else begin
          outs[n] = CH_QMARK;
          n++;
          reread = 1'b1;
        end
      end
      default: reread = 1'b1;
    endcase
    if (reread) begin
      if (b == CH_BSLASH && !fin) begin
        esc_phase = PH_ESC;
      end else begin
        outs[n] = b;
        n++;
      end
    end
    if (esc_phase != PH_HI) begin
      nib_hold = 4'h0;
    end
    if (fin) begin
      esc_phase = PH_NORMAL;
      nib_hold = 4'h0;
    end
    for (int k = 0; k < n; k++) begin
      r.char_out = outs[k];
      r.run_end = (k == n - 1);
      r.string_done = (k == n - 1) && fin;
      decoded_q.insert(decoded_q.size(), r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      esc_phase = PH_NORMAL;
      nib_hold = 4'h0;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("char_out: expected none, got %h", char_out);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          if (char_out !== want.char_out) begin
            $error("char_out: expected %h, got %h", want.char_out, char_out);
            errs++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, run_end);
            errs++;
          end
          if (string_done !== want.string_done) begin
            $error("string_done: expected %b, got %b", want.string_done, string_done);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(char_in, is_final);
      end
    end
    mismatches <= errs;
    pending <= decoded_q.size();
  end

endmodule

// ===== verif/tb_escape_sequence_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_escape_sequence_decoder_unit;
  import esd_pkg::*;

  localparam int ITEM_GOAL   = 1425;
  localparam int CYCLE_LIMIT = 300000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_in;
  logic       is_final;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] char_out;
  logic       run_end;
  logic       string_done;

  int         mismatch_count;
  int         results_pending;
  logic [7:0] text_q[$];
  int         sent;
  int         burst_left;
  int         strings_sent;
  bit         long_hold_req;
  int         ready_mode;
  int         mode_left;
  int         hold_left;
  int         cycle_count;

  escape_sequence_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .run_end    (run_end),
    .string_done(string_done)
  );

  escape_decode_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .run_end    (run_end),
    .string_done(string_done),
    .mismatches (mismatch_count),
    .pending    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // The receiver follows a changing stall pattern, and on request holds off
  // for a long stretch so that the output queue fills and the input stalls.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    mode_left = 0;
    ready_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    char_in <= b;
    is_final <= fin;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 9))
      0: return CH_A;
      1: return CH_B;
      2: return CH_F;
      3: return CH_N;
      4: return CH_R;
      5: return CH_T;
      6: return CH_V;
      7: return CH_BSLASH;
      8: return CH_SQUOTE;
      default: return CH_DQUOTE;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) begin
      return 8'h30 + v;
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Mostly well-formed strings with random content, some broken escapes,
  // some truncated strings and some pure noise.
  task automatic gen_text();
    int         tokens;
    int         kind;
    int         cut;
    logic [7:0] b;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      return;
    end
    tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH) begin
          b = CH_QMARK;
        end
        text_q.insert(text_q.size(), b);
      end else if (kind < 60) begin
        text_q.insert(text_q.size(), CH_BSLASH);
        text_q.insert(text_q.size(), pick_escape());
      end else if (kind < 80) begin
        text_q.insert(text_q.size(), CH_BSLASH);
        text_q.insert(text_q.size(), CH_ZERO);
        text_q.insert(text_q.size(), CH_X);
        text_q.insert(text_q.size(), hex_char());
        text_q.insert(text_q.size(), hex_char());
      end else if (kind < 95) begin
        text_q.insert(text_q.size(), CH_BSLASH);
        case ($urandom_range(0, 3))
          0: ;
          1: text_q.insert(text_q.size(), CH_ZERO);
          2: begin
            text_q.insert(text_q.size(), CH_ZERO);
            text_q.insert(text_q.size(), CH_X);
          end
          default: begin
            text_q.insert(text_q.size(), CH_ZERO);
            text_q.insert(text_q.size(), CH_X);
            text_q.insert(text_q.size(), hex_char());
          end
        endcase
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end else begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) begin
        text_q.delete(text_q.size() - 1);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    char_in <= 8'h00;
    is_final <= 1'b0;
    sent = 0;
    burst_left = 0;
    strings_sent = 0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();
    // A lone backslash at the end of a string passes through as itself.
    text_q = '{CH_BSLASH};
    send_text();
    text_q = '{CH_BSLASH, 8'h71};
    send_text();
    text_q = '{CH_BSLASH, CH_ZERO, CH_X, 8'h41, 8'h66};
    send_text();
    text_q = '{CH_BSLASH, CH_ZERO, CH_X, 8'h67};
    send_text();
    text_q = '{CH_BSLASH, CH_ZERO, CH_X, CH_BSLASH, CH_N};
    send_text();
    text_q = '{CH_BSLASH, CH_ZERO, CH_X, 8'h35};
    send_text();
    text_q = '{CH_BSLASH, CH_ZERO};
    send_text();
    drain_results();

    while (sent < ITEM_GOAL) begin
      if (strings_sent == 40 || strings_sent == 300) begin
        long_hold_req = 1'b1;
        burst_left = 500;
      end
      if ($urandom_range(0, 29) == 0) begin
        drain_results();
      end
      gen_text();
      send_text();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
